// ===== rtl/core/atids_pkg.sv =====
// ============================================================================
// atids_pkg - shared types and codes for the sorted array table
// Operation and status codes, fixed field widths of the request and response
// beats, and the structs that pass between the top level, the engine and the comparator.
// ============================================================================
package atids_pkg;

    localparam int MODE_W     = 3;
    localparam int POS_W      = 5;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int INDEX_W    = 5;
    localparam int COUNT_W    = 5;
    localparam int DATA_OUT_W = 32;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SORTED = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SORT   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]          status;
        logic [INDEX_W-1:0]           index;
        logic [COUNT_W-1:0]           count;
        logic signed [DATA_OUT_W-1:0] data;
    } rsp_t;

    typedef struct packed {
        logic start;
        logic take;
    } eng_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

// ===== rtl/core/atids_req_if.sv =====
// ============================================================================
// atids_req_if - request channel
// Valid/ready channel carrying one operation request per beat.
// ============================================================================
interface atids_req_if;

    logic                                  valid;
    logic                                  ready;
    logic [atids_pkg::MODE_W-1:0]          mode;
    logic [atids_pkg::POS_W-1:0]           position;
    logic signed [atids_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);

endinterface

// ===== rtl/core/atids_rsp_if.sv =====
// ============================================================================
// atids_rsp_if - response channel
// Valid/ready channel carrying one result per beat.
// ============================================================================
interface atids_rsp_if;

    logic                                     valid;
    logic                                     ready;
    logic [atids_pkg::STATUS_W-1:0]           status;
    logic [atids_pkg::INDEX_W-1:0]            index;
    logic [atids_pkg::COUNT_W-1:0]            count;
    logic signed [atids_pkg::DATA_OUT_W-1:0]  data;

    modport source (output valid, output status, output index, output count, output data,
                    input ready);
    modport sink   (input valid, input status, input index, input count, input data,
                    output ready);

endinterface

// ===== rtl/core/atids_cmp.sv =====
// ============================================================================
// atids_cmp - shared word comparator
// Signed less-than and equality of two words, used by every scan.
// ============================================================================
module atids_cmp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output atids_pkg::cmp_res_t   res
);

    assign res.lt = $signed(a) < $signed(b);
    assign res.eq = (a == b);

endmodule

// ===== rtl/core/atids_engine.sv =====
// ============================================================================
// atids_engine - table storage and operation sequencer
// Holds the entry memory and the fill count, and steps each operation through
// the memory one entry at a time using the shared comparator.
// ============================================================================
module atids_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  atids_pkg::eng_ctl_t  ctl,
    input  atids_pkg::req_t      req,
    output atids_pkg::eng_stat_t stat,
    output atids_pkg::rsp_t      result
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PCW    = (CNT_W > atids_pkg::POS_W) ? CNT_W : atids_pkg::POS_W;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISPATCH = 5'd1;
    localparam logic [4:0] S_RD_DATA  = 5'd2;
    localparam logic [4:0] S_SU_CHK   = 5'd3;
    localparam logic [4:0] S_SU_WR    = 5'd4;
    localparam logic [4:0] S_PLACE    = 5'd5;
    localparam logic [4:0] S_SD_CHK   = 5'd6;
    localparam logic [4:0] S_SD_WR    = 5'd7;
    localparam logic [4:0] S_SO_CHK   = 5'd8;
    localparam logic [4:0] S_SO_LOAD  = 5'd9;
    localparam logic [4:0] S_SO_RD    = 5'd10;
    localparam logic [4:0] S_SO_CMP   = 5'd11;
    localparam logic [4:0] S_SO_STORE = 5'd12;
    localparam logic [4:0] S_FI_CHK   = 5'd13;
    localparam logic [4:0] S_FI_CMP   = 5'd14;
    localparam logic [4:0] S_SC_CHK   = 5'd15;
    localparam logic [4:0] S_SC_CMP   = 5'd16;
    localparam logic [4:0] S_FINISH   = 5'd17;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata;

    logic [4:0]                     state_reg,  state_next;
    logic [CNT_W-1:0]               count_reg,  count_next;
    logic [CNT_W-1:0]               i_reg,      i_next;
    logic [CNT_W-1:0]               j_reg,      j_next;
    logic [CNT_W-1:0]               tgt_reg,    tgt_next;
    logic [CNT_W-1:0]               idx_reg,    idx_next;
    logic [DATA_WIDTH-1:0]          cur_reg,    cur_next;
    logic [DATA_WIDTH-1:0]          data_reg,   data_next;
    logic [atids_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                           found_reg,  found_next;
    logic [atids_pkg::MODE_W-1:0]   mode_reg;
    logic [PCW-1:0]                 pos_reg;
    logic [DATA_WIDTH-1:0]          val_reg;

    logic [CNT_W-1:0]      i_inc;
    logic [CNT_W-1:0]      i_dec;
    logic [CNT_W-1:0]      j_inc;
    logic [PCW-1:0]        cnt_ext;
    logic                  full;
    logic [DATA_WIDTH-1:0] cmp_b;
    atids_pkg::cmp_res_t   cmp;

    assign i_inc   = i_reg + CNT_W'(1);
    assign i_dec   = i_reg - CNT_W'(1);
    assign j_inc   = j_reg + CNT_W'(1);
    assign cnt_ext = PCW'(count_reg);
    assign full    = (count_reg == CNT_W'(DEPTH));

    atids_cmp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cmp (
        .a   (rd_data_reg),
        .b   (cmp_b),
        .res (cmp)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        tgt_next    = tgt_reg;
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        data_next   = data_reg;
        status_next = status_reg;
        found_next  = found_reg;
        mem_we      = 1'b0;
        mem_waddr   = i_reg[ADDR_W-1:0];
        mem_wdata   = rd_data_reg;
        mem_raddr   = i_reg[ADDR_W-1:0];
        cmp_b       = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                status_next = atids_pkg::STATUS_OK;
                idx_next    = '0;
                data_next   = '0;
                found_next  = 1'b0;
                i_next      = '0;
                unique case (mode_reg) inside
                    atids_pkg::MODE_INSERT:
                    begin
                        if (full)
                        begin
                            status_next = atids_pkg::STATUS_FULL;
                            state_next  = S_FINISH;
                        end
                        else if (pos_reg > cnt_ext)
                        begin
                            status_next = atids_pkg::STATUS_RANGE;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            tgt_next   = CNT_W'(pos_reg);
                            i_next     = count_reg;
                            state_next = S_SU_CHK;
                        end
                    end
                    atids_pkg::MODE_DELETE:
                    begin
                        if (pos_reg >= cnt_ext)
                        begin
                            status_next = atids_pkg::STATUS_RANGE;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            i_next     = CNT_W'(pos_reg);
                            state_next = S_SD_CHK;
                        end
                    end
                    atids_pkg::MODE_SORTED, atids_pkg::MODE_SORT:
                    begin
                        state_next = S_SO_CHK;
                    end
                    atids_pkg::MODE_SEARCH:
                    begin
                        state_next = S_SC_CHK;
                    end
                    atids_pkg::MODE_READ:
                    begin
                        if (pos_reg >= cnt_ext)
                        begin
                            status_next = atids_pkg::STATUS_RANGE;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            mem_raddr  = pos_reg[ADDR_W-1:0];
                            state_next = S_RD_DATA;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_RD_DATA:
            begin
                data_next  = rd_data_reg;
                idx_next   = CNT_W'(pos_reg);
                state_next = S_FINISH;
            end
            // Open a gap at the target by moving entries up, top one first.
            S_SU_CHK:
            begin
                if (i_reg == tgt_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    mem_raddr  = i_dec[ADDR_W-1:0];
                    state_next = S_SU_WR;
                end
            end
            S_SU_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = i_reg[ADDR_W-1:0];
                mem_wdata  = rd_data_reg;
                i_next     = i_dec;
                state_next = S_SU_CHK;
            end
            S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = tgt_reg[ADDR_W-1:0];
                mem_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
                idx_next   = tgt_reg;
                state_next = S_FINISH;
            end
            // Close the gap left by a delete, moving entries down.
            S_SD_CHK:
            begin
                if (i_inc >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    idx_next   = CNT_W'(pos_reg);
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_raddr  = i_inc[ADDR_W-1:0];
                    state_next = S_SD_WR;
                end
            end
            S_SD_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = i_reg[ADDR_W-1:0];
                mem_wdata  = rd_data_reg;
                i_next     = i_inc;
                state_next = S_SD_CHK;
            end
            // Exchange sort: the entry at i is held in cur_reg while the
            // entries above it are scanned, and written back at the end.
            S_SO_CHK:
            begin
                if (i_inc >= count_reg)
                begin
                    if (mode_reg == atids_pkg::MODE_SORTED)
                    begin
                        if (full)
                        begin
                            status_next = atids_pkg::STATUS_FULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            i_next     = '0;
                            state_next = S_FI_CHK;
                        end
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    mem_raddr  = i_reg[ADDR_W-1:0];
                    state_next = S_SO_LOAD;
                end
            end
            S_SO_LOAD:
            begin
                cur_next   = rd_data_reg;
                j_next     = i_inc;
                state_next = S_SO_RD;
            end
            S_SO_RD:
            begin
                mem_raddr  = j_reg[ADDR_W-1:0];
                state_next = S_SO_CMP;
            end
            S_SO_CMP:
            begin
                cmp_b = cur_reg;
                if (cmp.lt)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = j_reg[ADDR_W-1:0];
                    mem_wdata = cur_reg;
                    cur_next  = rd_data_reg;
                end
                j_next = j_inc;
                if (j_inc >= count_reg)
                begin
                    state_next = S_SO_STORE;
                end
                else
                begin
                    state_next = S_SO_RD;
                end
            end
            S_SO_STORE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = i_reg[ADDR_W-1:0];
                mem_wdata  = cur_reg;
                i_next     = i_inc;
                state_next = S_SO_CHK;
            end
            // Find the first entry not less than the value, then reuse the
            // positional insert from there.
            S_FI_CHK:
            begin
                if (i_reg >= count_reg)
                begin
                    tgt_next   = i_reg;
                    i_next     = count_reg;
                    state_next = S_SU_CHK;
                end
                else
                begin
                    mem_raddr  = i_reg[ADDR_W-1:0];
                    state_next = S_FI_CMP;
                end
            end
            S_FI_CMP:
            begin
                if (cmp.lt)
                begin
                    i_next     = i_inc;
                    state_next = S_FI_CHK;
                end
                else
                begin
                    tgt_next   = i_reg;
                    i_next     = count_reg;
                    state_next = S_SU_CHK;
                end
            end
            S_SC_CHK:
            begin
                if (i_reg >= count_reg)
                begin
                    if (found_reg)
                    begin
                        data_next = val_reg;
                    end
                    else
                    begin
                        status_next = atids_pkg::STATUS_NOT_FOUND;
                        idx_next    = '0;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_raddr  = i_reg[ADDR_W-1:0];
                    state_next = S_SC_CMP;
                end
            end
            S_SC_CMP:
            begin
                if (cmp.eq)
                begin
                    found_next = 1'b1;
                    idx_next   = i_reg;
                end
                i_next     = i_inc;
                state_next = S_SC_CHK;
            end
            S_FINISH:
            begin
                if (ctl.take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        tgt_reg    <= tgt_next;
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        if (state_reg == S_IDLE && ctl.start)
        begin
            mode_reg <= req.mode;
            pos_reg  <= PCW'(req.position);
            val_reg  <= DATA_WIDTH'($unsigned(req.value));
        end
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_FINISH);

    assign result.status = status_reg;
    assign result.index  = atids_pkg::INDEX_W'(idx_reg);
    assign result.count  = atids_pkg::COUNT_W'(count_reg);
    assign result.data   = atids_pkg::DATA_OUT_W'(data_reg);

endmodule

// ===== rtl/core/array_table_insert_delete_sort_top.sv =====
// ============================================================================
// array_table_insert_delete_sort_top - bounded sorted array table
// Keeps up to DEPTH signed words with insert, delete, sorted insert, search,
// sort and read operations, one response beat per request beat.
// ============================================================================
//
//  channel | direction | beat contents                      | handshake
//  --------+-----------+------------------------------------+-----------
//  req     | in        | mode, position, value              | valid/ready
//  rsp     | out       | status, index, count, data         | valid/ready
//
//  One request is worked at a time through the entry memory, which has one
//  read port and one write port; each entry visited takes a read step, then
//  a compare or write step. Sorted insert runs the sort, then the search
//  for its slot, then the shift.
//  After reset the fill count is zero; entry contents are left as they are.
//  A result waiting in the output register does not hold up the next request;
//  the engine only stalls when a second result is ready before the first is
//  taken.
//
module array_table_insert_delete_sort_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    atids_req_if.sink   req,
    atids_rsp_if.source rsp
);

    atids_pkg::eng_ctl_t  ctl;
    atids_pkg::eng_stat_t stat;
    atids_pkg::req_t      req_word;
    atids_pkg::rsp_t      result;
    atids_pkg::rsp_t      rsp_word_reg;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;

    assign req_word.mode     = req.mode;
    assign req_word.position = req.position;
    assign req_word.value    = req.value;

    assign req.ready = stat.idle;
    assign ctl.start = req.valid && stat.idle;
    // The engine hands over its result only when the output register is free or its beat is being taken.
    assign ctl.take  = stat.done && (!rsp_valid_reg || rsp.ready);

    atids_engine #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .req    (req_word),
        .stat   (stat),
        .result (result)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            rsp_word_reg <= result;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_word_reg.status;
    assign rsp.index  = rsp_word_reg.index;
    assign rsp.count  = rsp_word_reg.count;
    assign rsp.data   = rsp_word_reg.data;

endmodule

// ===== rtl/core/atids_checker.sv =====
// ============================================================================
// atids_checker - port-level checks for the array table
// Watches the request and response channels of the top level over time.
// ============================================================================
module atids_checker #(
    parameter int DEPTH = 16
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  req_valid,
    input logic                                  req_ready,
    input logic                                  rsp_valid,
    input logic                                  rsp_ready,
    input logic [atids_pkg::STATUS_W-1:0]        rsp_status,
    input logic [atids_pkg::INDEX_W-1:0]         rsp_index,
    input logic [atids_pkg::COUNT_W-1:0]         rsp_count,
    input logic signed [atids_pkg::DATA_OUT_W-1:0] rsp_data
);

    // A response beat that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped while stalled");

    // Once a request beat is taken, the table is busy on the next cycle.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one in progress");

    // A full status is only reported when the table holds DEPTH entries.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == atids_pkg::STATUS_FULL)
            |-> (rsp_count == atids_pkg::COUNT_W'(DEPTH)))
        else $error("full status with table not full");

    // Failed lookups and range errors carry neither an index nor data.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == atids_pkg::STATUS_NOT_FOUND)
                      || (rsp_status == atids_pkg::STATUS_RANGE))
            |-> (rsp_index == '0) && (rsp_data == '0))
        else $error("error response with non-zero index or data");

endmodule

bind array_table_insert_delete_sort_top atids_checker #(
    .DEPTH (DEPTH)
) u_atids_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_index  (rsp.index),
    .rsp_count  (rsp.count),
    .rsp_data   (rsp.data)
);

// ===== tb/array_table_insert_delete_sort_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// array_table_insert_delete_sort_top_tb - self-checking bench for the table
// Drives request beats through the valid/ready channel and keeps a shadow copy
// of the table that predicts each response beat. Directed cases cover the
// empty and full table and every operation. Random traffic then runs under
// three sender and receiver idle profiles.
// ============================================================================
module array_table_insert_delete_sort_top_tb;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 500;

    localparam logic [atids_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [atids_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;

    localparam logic signed [atids_pkg::VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [atids_pkg::VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;

    logic clk;
    logic rst_n;

    atids_req_if req_ch ();
    atids_rsp_if rsp_ch ();

    array_table_insert_delete_sort_top #(
        .DEPTH      (TABLE_DEPTH),
        .DATA_WIDTH (atids_pkg::VALUE_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the table contents and fill count.
    logic signed [atids_pkg::VALUE_W-1:0] shadow_table [TABLE_DEPTH];
    int                                   shadow_fill;

    atids_pkg::rsp_t expected_q [$];
    int              errors;
    int              send_idle_pct;
    int              recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #25_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void sort_shadow();
        logic signed [atids_pkg::VALUE_W-1:0] tmp;
        for (int i = 0; i + 1 < shadow_fill; i++)
        begin
            for (int j = i + 1; j < shadow_fill; j++)
            begin
                if (shadow_table[j] < shadow_table[i])
                begin
                    tmp             = shadow_table[i];
                    shadow_table[i] = shadow_table[j];
                    shadow_table[j] = tmp;
                end
            end
        end
    endfunction

    function automatic void place_shadow(input int slot,
                                         input logic signed [atids_pkg::VALUE_W-1:0] v);
        for (int i = shadow_fill; i > slot; i--)
            shadow_table[i] = shadow_table[i-1];
        shadow_table[slot] = v;
        shadow_fill++;
    endfunction

    // Applies one request to the shadow table and returns the response it causes.
    function automatic atids_pkg::rsp_t predict_table_op(input atids_pkg::req_t r);
        atids_pkg::rsp_t res;
        int              slot;
        bit              hit;
        res = '0;
        case (r.mode)
            atids_pkg::MODE_INSERT:
            begin
                if (shadow_fill >= TABLE_DEPTH)
                    res.status = atids_pkg::STATUS_FULL;
                else if (int'(r.position) > shadow_fill)
                    res.status = atids_pkg::STATUS_RANGE;
                else
                begin
                    place_shadow(int'(r.position), r.value);
                    res.index = r.position;
                end
            end
            atids_pkg::MODE_DELETE:
            begin
                if (int'(r.position) >= shadow_fill)
                    res.status = atids_pkg::STATUS_RANGE;
                else
                begin
                    for (int i = int'(r.position); i + 1 < shadow_fill; i++)
                        shadow_table[i] = shadow_table[i+1];
                    shadow_fill--;
                    res.index = r.position;
                end
            end
            atids_pkg::MODE_SORTED:
            begin
                sort_shadow();
                if (shadow_fill >= TABLE_DEPTH)
                    res.status = atids_pkg::STATUS_FULL;
                else
                begin
                    slot = 0;
                    while (slot < shadow_fill && shadow_table[slot] < r.value)
                        slot++;
                    place_shadow(slot, r.value);
                    res.index = atids_pkg::INDEX_W'(slot);
                end
            end
            atids_pkg::MODE_SEARCH:
            begin
                hit = 1'b0;
                for (int i = 0; i < shadow_fill; i++)
                begin
                    if (shadow_table[i] == r.value)
                    begin
                        hit       = 1'b1;
                        res.index = atids_pkg::INDEX_W'(i);
                    end
                end
                if (hit)
                    res.data = r.value;
                else
                    res.status = atids_pkg::STATUS_NOT_FOUND;
            end
            atids_pkg::MODE_SORT:
                sort_shadow();
            atids_pkg::MODE_READ:
            begin
                if (int'(r.position) >= shadow_fill)
                    res.status = atids_pkg::STATUS_RANGE;
                else
                begin
                    res.index = r.position;
                    res.data  = shadow_table[r.position];
                end
            end
            default: ;
        endcase
        res.count = atids_pkg::COUNT_W'(shadow_fill);
        return res;
    endfunction

    // Sends one request beat and records the response it should produce.
    // Valid is left high so that a following beat can go out back to back.
    task automatic send_request(input logic [atids_pkg::MODE_W-1:0] m,
                                input logic [atids_pkg::POS_W-1:0] p,
                                input logic signed [atids_pkg::VALUE_W-1:0] v);
        atids_pkg::req_t beat;
        bit              taken;
        beat.mode     = m;
        beat.position = p;
        beat.value    = v;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= m;
        req_ch.position <= p;
        req_ch.value    <= v;
        do
        begin
            @(negedge clk);
            taken = (req_ch.ready === 1'b1);
            @(posedge clk);
        end
        while (!taken);
        expected_q.push_back(predict_table_op(beat));
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [atids_pkg::VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
        begin
            case ($urandom_range(4))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return 32'sd0;
                3:       return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        else if (sel < 50)
            return $signed(32'($urandom_range(15))) - 32'sd8;
        return $signed($urandom);
    endfunction

    task automatic test_empty_table();
        send_request(atids_pkg::MODE_READ, 5'd0, 32'sd0);
        send_request(atids_pkg::MODE_DELETE, 5'd31, 32'sd0);
        send_request(atids_pkg::MODE_SEARCH, 5'd0, 32'sd0);
        send_request(atids_pkg::MODE_SORT, 5'd0, 32'sd0);
        send_request(MODE_SPARE_A, 5'd31, -32'sd1);
        send_request(MODE_SPARE_B, 5'd0, WORD_MAX);
        send_request(atids_pkg::MODE_INSERT, 5'd1, 32'sd7);
    endtask

    task automatic test_positional_and_full();
        send_request(atids_pkg::MODE_INSERT, 5'd0, WORD_MAX);
        send_request(atids_pkg::MODE_INSERT, 5'd1, WORD_MIN);
        send_request(atids_pkg::MODE_INSERT, 5'd1, -32'sd1);
        send_request(atids_pkg::MODE_INSERT, 5'd0, 32'sd0);
        send_request(atids_pkg::MODE_SORTED, 5'd0, 32'sd5);
        send_request(atids_pkg::MODE_SEARCH, 5'd0, WORD_MIN);
        send_request(atids_pkg::MODE_READ, 5'd4, 32'sd0);
        send_request(atids_pkg::MODE_READ, 5'd5, 32'sd0);
        send_request(atids_pkg::MODE_SORT, 5'd0, 32'sd0);
        // Fill the rest with duplicates of a few values so that search meets repeats.
        while (shadow_fill < TABLE_DEPTH)
            send_request(atids_pkg::MODE_SORTED, 5'd0, $signed(32'($urandom_range(3))));
        send_request(atids_pkg::MODE_INSERT, 5'd16, 32'sd9);
        send_request(atids_pkg::MODE_SORTED, 5'd0, 32'sd3);
        send_request(atids_pkg::MODE_READ, 5'd15, 32'sd0);
        send_request(atids_pkg::MODE_SEARCH, 5'd0, 32'sd2);
        send_request(atids_pkg::MODE_DELETE, 5'd0, 32'sd0);
        // Hold the sender off until the table has answered everything.
        wait_for_results();
        send_request(atids_pkg::MODE_DELETE, 5'd15, 32'sd0);
    endtask

    task automatic test_random_ops(input int n_items, input int tx_idle, input int rx_idle);
        int                                   pick;
        logic [atids_pkg::MODE_W-1:0]         m;
        logic [atids_pkg::POS_W-1:0]          p;
        logic signed [atids_pkg::VALUE_W-1:0] v;
        wait_for_results();
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        for (int k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 22)
                m = atids_pkg::MODE_INSERT;
            else if (pick < 40)
                m = atids_pkg::MODE_SORTED;
            else if (pick < 58)
                m = atids_pkg::MODE_DELETE;
            else if (pick < 73)
                m = atids_pkg::MODE_SEARCH;
            else if (pick < 88)
                m = atids_pkg::MODE_READ;
            else if (pick < 95)
                m = atids_pkg::MODE_SORT;
            else
                m = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
            // A full table drains again rather than sitting at capacity.
            if (shadow_fill == TABLE_DEPTH && $urandom_range(1))
                m = atids_pkg::MODE_DELETE;
            if ($urandom_range(99) < 80)
                p = atids_pkg::POS_W'($urandom_range(shadow_fill));
            else
                p = atids_pkg::POS_W'($urandom_range(31));
            if (m == atids_pkg::MODE_SEARCH && shadow_fill > 0 && $urandom_range(99) < 60)
                v = shadow_table[$urandom_range(shadow_fill - 1)];
            else
                v = pick_value();
            send_request(m, p, v);
        end
    endtask

    // Response ready with random stalls.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Values are stable at the falling edge, and a beat seen there with valid
    // and ready both high is taken at the next rising edge.
    initial
    begin
        atids_pkg::rsp_t want;
        atids_pkg::rsp_t got;
        errors = 0;
        forever
        begin
            @(negedge clk);
            if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.status = rsp_ch.status;
                got.index  = rsp_ch.index;
                got.count  = rsp_ch.count;
                got.data   = rsp_ch.data;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: response beat with nothing outstanding", $realtime);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status || got.index !== want.index ||
                        got.count !== want.count || got.data !== want.data)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("%0t: mismatch, expected status %0d index %0d count %0d data %0d",
                                     $realtime, want.status, want.index, want.count, want.data);
                            $display("    actual status %0d index %0d count %0d data %0d",
                                     got.status, got.index, got.count, got.data);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.mode     <= atids_pkg::MODE_INSERT;
        req_ch.position <= '0;
        req_ch.value    <= '0;
        shadow_fill     = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            shadow_table[i] = '0;
        send_idle_pct = 17;
        recv_idle_pct = 73;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_positional_and_full();
        test_random_ops(650, 17, 73);
        test_random_ops(650, 73, 17);
        test_random_ops(650, 0, 0);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
